// ===== design/rcfu_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the RC frame channel unpacker.
package rcfu_pkg;

	localparam int FRAME_LEN  = 25;
	localparam int DATA_BYTES = 22;
	localparam int NUM_CHANS  = 16;
	localparam int CHAN_W     = 11;
	localparam int FRAME_W    = DATA_BYTES * 8;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);
	localparam int POS_W      = $clog2(FRAME_LEN);
	localparam int BIDX_W     = $clog2(DATA_BYTES);
	localparam int CIDX_W     = $clog2(NUM_CHANS);

	localparam logic [7:0] START_BYTE = 8'h0F;

	typedef logic [7:0]         byte_t;
	typedef logic [POS_W-1:0]   pos_t;
	typedef logic [BIDX_W-1:0]  byte_idx_t;
	typedef logic [CIDX_W-1:0]  chan_idx_t;
	typedef logic [CHAN_W-1:0]  chan_val_t;
	typedef logic [FRAME_W-1:0] frame_t;
	typedef logic [QPTR_W-1:0]  qptr_t;
	typedef logic [QCNT_W-1:0]  qcnt_t;

	localparam pos_t      LAST_POS  = pos_t'(FRAME_LEN - 1);
	localparam pos_t      FIRST_DATA_POS = pos_t'(1);
	localparam pos_t      LAST_DATA_POS  = pos_t'(DATA_BYTES);
	localparam chan_idx_t LAST_CHAN = chan_idx_t'(NUM_CHANS - 1);

endpackage

// ===== design/rcfu_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for received bytes and channel words.
interface rcfu_byte_if;
	logic             valid;
	logic             ready;
	rcfu_pkg::byte_t  rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rcfu_chan_if;
	logic                 valid;
	logic                 ready;
	rcfu_pkg::chan_idx_t  channel_index;
	rcfu_pkg::chan_val_t  channel_value;
	logic                 last_channel;

	modport source (output valid, output channel_index, output channel_value,
		output last_channel, input ready);
	modport sink   (input valid, input channel_index, input channel_value,
		input last_channel, output ready);
endinterface

// ===== design/rc_frame_channel_unpacker_core.sv =====
`timescale 1ns / 1ps
// Top level of the RC frame channel unpacker.
// Accepts one received byte per cycle, syncing on the start byte 0x0F (which
// restarts the frame wherever it appears) and storing data bytes 1..22; a
// frame completes on its 25th byte. Each completed frame enters a two-frame
// queue, and the unpacker sends its sixteen 11-bit channel words, one per
// cycle while the output is ready, through a registered output, marking
// channel 15 as last. A completed frame is pushed into the queue, and its
// first channel word is loaded from the queue head into the output register.
// The input stalls only while both queue slots hold frames not yet fully
// unpacked into the output register, which is set by how fast the output
// side takes its sixteen words per frame.
module rc_frame_channel_unpacker_core (
	input  logic        clk,
	input  logic        arst_n,
	rcfu_byte_if.sink   rx_bytes,
	rcfu_chan_if.source channels
);
	import rcfu_pkg::*;

	logic   push;
	frame_t push_frame;
	logic   full;
	logic   pop;
	logic   head_valid;
	frame_t head_frame;

	rcfu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx_bytes   (rx_bytes),
		.queue_full (full),
		.push       (push),
		.push_frame (push_frame)
	);

	rcfu_frame_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_frame (push_frame),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_frame (head_frame)
	);

	rcfu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_frame (head_frame),
		.pop        (pop),
		.channels   (channels)
	);

endmodule

// ===== design/rcfu_front.sv =====
`timescale 1ns / 1ps
// Front end: frame sync on the start byte, byte store and frame handoff.
module rcfu_front (
	input  logic             clk,
	input  logic             arst_n,
	rcfu_byte_if.sink        rx_bytes,
	input  logic             queue_full,
	output logic             push,
	output rcfu_pkg::frame_t push_frame
);
	import rcfu_pkg::*;

	pos_t  pos_q;
	byte_t bytes_q [DATA_BYTES];
	logic  accept;
	logic  is_start;
	logic  store_en;
	byte_idx_t store_idx;

	assign rx_bytes.ready = !queue_full;
	assign accept    = rx_bytes.valid && rx_bytes.ready;
	assign is_start  = (rx_bytes.rx_byte == START_BYTE);
	assign store_en  = accept && !is_start && (pos_q >= FIRST_DATA_POS)
		&& (pos_q <= LAST_DATA_POS);
	assign store_idx = byte_idx_t'(pos_q - FIRST_DATA_POS);
	// frame done when the footer position is filled by a non-start byte
	assign push      = accept && !is_start && (pos_q == LAST_POS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			if (is_start) begin
				pos_q <= FIRST_DATA_POS;
			end else if (pos_q == LAST_POS) begin
				pos_q <= '0;
			end else if (pos_q != '0) begin
				pos_q <= pos_q + pos_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (store_en) begin
			bytes_q[store_idx] <= rx_bytes.rx_byte;
		end
	end

	always_comb begin
		for (int i = 0; i < DATA_BYTES; i++) begin
			push_frame[i*8 +: 8] = bytes_q[i];
		end
	end

endmodule

// ===== design/rcfu_frame_queue.sv =====
`timescale 1ns / 1ps
// Short queue of completed frames between front end and unpacker.
module rcfu_frame_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  rcfu_pkg::frame_t push_frame,
	output logic             full,
	input  logic             pop,
	output logic             head_valid,
	output rcfu_pkg::frame_t head_frame
);
	import rcfu_pkg::*;

	frame_t entries_q [QUEUE_DEPTH];
	qptr_t  wptr_q;
	qptr_t  rptr_q;
	qcnt_t  cnt_q;
	logic   do_push;
	logic   do_pop;

	assign full       = (cnt_q == qcnt_t'(QUEUE_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_frame = entries_q[rptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	function automatic qptr_t next_ptr(input qptr_t p);
		return (p == qptr_t'(QUEUE_DEPTH - 1)) ? '0 : p + qptr_t'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= next_ptr(wptr_q);
			end
			if (do_pop) begin
				rptr_q <= next_ptr(rptr_q);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + qcnt_t'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - qcnt_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wptr_q] <= push_frame;
		end
	end

endmodule

// ===== design/rcfu_back.sv =====
`timescale 1ns / 1ps
// Back end: unpacks one 11-bit channel per cycle from the head frame while the output register can advance.
module rcfu_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  rcfu_pkg::frame_t head_frame,
	output logic             pop,
	rcfu_chan_if.source      channels
);
	import rcfu_pkg::*;

	chan_idx_t idx_q;
	logic      valid_q;
	chan_idx_t out_idx_q;
	chan_val_t out_val_q;
	logic      out_last_q;
	logic      advance;
	logic      take;

	assign advance = !valid_q || channels.ready;
	assign take    = advance && head_valid;
	// release the frame once its last channel is in the output register
	assign pop     = take && (idx_q == LAST_CHAN);

	assign channels.valid         = valid_q;
	assign channels.channel_index = out_idx_q;
	assign channels.channel_value = out_val_q;
	assign channels.last_channel  = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (advance) begin
			valid_q <= head_valid;
			if (head_valid) begin
				idx_q <= idx_q + chan_idx_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_idx_q  <= idx_q;
			out_val_q  <= head_frame[CHAN_W*idx_q +: CHAN_W];
			out_last_q <= (idx_q == LAST_CHAN);
		end
	end

endmodule

// ===== design/rcfu_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks of the unpacker, bound to the top level.
module rcfu_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_ready,
	input rcfu_pkg::chan_idx_t out_index,
	input rcfu_pkg::chan_val_t out_value,
	input logic                out_last
);
	import rcfu_pkg::*;

	chan_idx_t exp_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_idx_q <= '0;
		end else if (out_valid && out_ready) begin
			exp_idx_q <= exp_idx_q + chan_idx_t'(1);
		end
	end

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("channel word dropped while stalled");

	a_word_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_value) && $stable(out_index))
		else $error("channel word changed while stalled");

	a_last_mark: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_last == (out_index == LAST_CHAN)))
		else $error("last mark not on channel 15");

	a_index_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_index == exp_idx_q))
		else $error("channel index out of sequence");

endmodule

bind rc_frame_channel_unpacker_core rcfu_checker u_rcfu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (channels.valid),
	.out_ready (channels.ready),
	.out_index (channels.channel_index),
	.out_value (channels.channel_value),
	.out_last  (channels.last_channel)
);
